FILE: rtl/core/pdc_pkg.sv
// pdc_pkg: shared types, constants and lane arithmetic for the Porter-Duff compositor
// holds the composition mode codes and the rounded byte multiply helpers
// no dependencies
package pdc_pkg;

	localparam int LANES  = 4;
	localparam int BYTE_W = 8;
	localparam int LANE_W = 16;
	localparam int MODE_W = 4;

	localparam logic [LANE_W-1:0] ROUND_BIAS = 16'h0080;
	localparam logic [LANE_W-1:0] LANE_MAX   = 16'hffff;
	localparam logic [BYTE_W-1:0] BYTE_FULL  = 8'hff;

	typedef logic [LANES-1:0][BYTE_W-1:0] pixel_t;

	// composition mode codes, 12 to 15 behave as destination
	typedef enum logic [MODE_W-1:0] {
		MODE_SRC_OVER  = 4'd0,
		MODE_DST_OVER  = 4'd1,
		MODE_CLEAR     = 4'd2,
		MODE_SOURCE    = 4'd3,
		MODE_DEST      = 4'd4,
		MODE_SRC_IN    = 4'd5,
		MODE_DST_IN    = 4'd6,
		MODE_SRC_OUT   = 4'd7,
		MODE_DST_OUT   = 4'd8,
		MODE_SRC_ATOP  = 4'd9,
		MODE_DST_ATOP  = 4'd10,
		MODE_XOR       = 4'd11
	} comp_mode_t;

	// 16-bit add saturating at all ones
	function automatic logic [LANE_W-1:0] sat_add16(input logic [LANE_W-1:0] a,
			input logic [LANE_W-1:0] b);
		logic [LANE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[LANE_W] ? LANE_MAX : s[LANE_W-1:0];
	endfunction

	// (t + 0x80, then t + (t >> 8)) >> 8 with saturating adds
	function automatic logic [BYTE_W-1:0] lane_round(input logic [LANE_W-1:0] t);
		logic [LANE_W-1:0] r1;
		logic [LANE_W-1:0] r2;
		r1 = sat_add16(t, ROUND_BIAS);
		r2 = sat_add16(r1, {{BYTE_W{1'b0}}, r1[LANE_W-1:BYTE_W]});
		return r2[LANE_W-1:BYTE_W];
	endfunction

	// rounded byte multiply, the product of two bytes never wraps
	function automatic logic [BYTE_W-1:0] bmul8(input logic [BYTE_W-1:0] a,
			input logic [BYTE_W-1:0] b);
		logic [LANE_W-1:0] p;
		p = {{BYTE_W{1'b0}}, a} * {{BYTE_W{1'b0}}, b};
		return lane_round(p);
	endfunction

endpackage

FILE: rtl/core/porter_duff_pixel_compositor_top.sv
// porter_duff_pixel_compositor_top: premultiplied ARGB32 Porter-Duff compositor
// depends on pdc_pkg for mode codes and rounded byte multiply helpers

// One pixel per clock while pix_stall is low, fully pipelined: an accepted item
// passes the stage registers and the output register to res_valid. The stages
// are the coverage scaling of source color and alphas, operand selection per
// mode, two lane multiplies, sum and rounding, then the final saturating add
// and clamp into the output register. A one-entry skid register behind the
// output absorbs the item in flight when res_stall rises, so pix_stall is a
// register and never follows res_stall in the same cycle. The user must write
// composition_mode through cfg_we/cfg_data only while the block is idle; the
// block does not enforce it; codes 12 to 15 pass dest_pixel through unchanged.
module porter_duff_pixel_compositor_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [3:0]  cfg_data,
	// pixel input channel
	input  logic        pix_valid,
	output logic        pix_stall,
	input  logic [31:0] src_pixel,
	input  logic [31:0] dest_pixel,
	input  logic [7:0]  coverage,
	input  logic        span_end,
	// result channel
	output logic        res_valid,
	input  logic        res_stall,
	output logic [31:0] result_pixel,
	output logic        span_end_out
);

	localparam int L = pdc_pkg::LANES;
	localparam int B = pdc_pkg::BYTE_W;
	localparam int W = pdc_pkg::LANE_W;

	pdc_pkg::comp_mode_t composition_mode_q;

	logic en;

	// stage 1: source scaled by coverage
	logic             vld_s1;
	logic             span_s1;
	pdc_pkg::pixel_t  s_s1, d_s1, ss_s1;
	logic [B-1:0]     ssa_s1, ca_s1, da_ca_s1, nda_ca_s1, nsa_ca_s1;
	logic             full_s1;

	// stage 2: operands of the final multiply-add
	logic                    vld_s2;
	logic                    span_s2;
	logic [L-1:0][B-1:0]     x_s2, y_s2, e_s2;
	logic [L-1:0][B:0]       a_s2, b_s2;
	logic [L-1:0][B-1:0]     x_c, y_c, e_c;
	logic [L-1:0][B:0]       a_c, b_c;

	// stage 3: lane products
	logic                    vld_s3;
	logic                    span_s3;
	logic [L-1:0][W-1:0]     p1_s3, p2_s3;
	logic [L-1:0][B-1:0]     e_s3;
	logic [L-1:0][W-1:0]     p1_c, p2_c;

	// stage 4: rounded blend
	logic                    vld_s4;
	logic                    span_s4;
	logic [L-1:0][B-1:0]     r_s4, e_s4;
	logic [L-1:0][B-1:0]     r_c;

	// output and skid
	logic                    out_vld_q, skid_vld_q;
	logic [31:0]             out_pix_q, skid_pix_q;
	logic                    out_span_q, skid_span_q;
	logic [31:0]             fin_c;
	logic                    load_out;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			composition_mode_q <= pdc_pkg::MODE_SRC_OVER;
		end else if (cfg_we) begin
			composition_mode_q <= pdc_pkg::comp_mode_t'(cfg_data);
		end
	end

	// pipeline moves whenever the skid register is empty
	assign en        = !skid_vld_q;
	assign pix_stall = skid_vld_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pix_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage 1 payload: coverage products
	always_ff @(posedge clk) begin
		if (en) begin
			logic full;
			full = (coverage == pdc_pkg::BYTE_FULL);
			span_s1   <= span_end;
			s_s1      <= src_pixel;
			d_s1      <= dest_pixel;
			ca_s1     <= coverage;
			full_s1   <= full;
			for (int l = 0; l < L; l++) begin
				ss_s1[l] <= full ? src_pixel[l*B +: B]
					: pdc_pkg::bmul8(src_pixel[l*B +: B], coverage);
			end
			ssa_s1    <= full ? src_pixel[31:24]
				: pdc_pkg::bmul8(src_pixel[31:24], coverage);
			da_ca_s1  <= pdc_pkg::bmul8(dest_pixel[31:24], coverage);
			nda_ca_s1 <= pdc_pkg::bmul8(~dest_pixel[31:24], coverage);
			nsa_ca_s1 <= pdc_pkg::bmul8(~src_pixel[31:24], coverage);
		end
	end

	// stage 2 logic: operand selection per mode, result is round(x*a + y*b) + e
	always_comb begin
		logic [B-1:0] sa, da, cia, nda, nsa, nssa;
		sa   = s_s1[L-1];
		da   = d_s1[L-1];
		cia  = ~ca_s1;
		nda  = ~da;
		nsa  = ~sa;
		nssa = ~ssa_s1;
		for (int l = 0; l < L; l++) begin
			x_c[l] = '0;
			a_c[l] = '0;
			y_c[l] = '0;
			b_c[l] = '0;
			e_c[l] = '0;
			case (composition_mode_q)
				pdc_pkg::MODE_SRC_OVER: begin
					e_c[l] = ss_s1[l];
					x_c[l] = d_s1[l];
					a_c[l] = {1'b0, nssa};
				end
				pdc_pkg::MODE_DST_OVER: begin
					e_c[l] = d_s1[l];
					x_c[l] = s_s1[l];
					a_c[l] = {1'b0, full_s1 ? nda : nda_ca_s1};
				end
				pdc_pkg::MODE_CLEAR: begin
					x_c[l] = d_s1[l];
					a_c[l] = {1'b0, cia};
				end
				pdc_pkg::MODE_SOURCE: begin
					if (full_s1) begin
						e_c[l] = s_s1[l];
					end else begin
						x_c[l] = s_s1[l];
						a_c[l] = {1'b0, ca_s1};
						y_c[l] = d_s1[l];
						b_c[l] = {1'b0, cia};
					end
				end
				pdc_pkg::MODE_SRC_IN: begin
					x_c[l] = s_s1[l];
					if (full_s1) begin
						a_c[l] = {1'b0, da};
					end else begin
						a_c[l] = {1'b0, da_ca_s1};
						y_c[l] = d_s1[l];
						b_c[l] = {1'b0, cia};
					end
				end
				pdc_pkg::MODE_DST_IN: begin
					x_c[l] = d_s1[l];
					a_c[l] = full_s1 ? {1'b0, sa} : {1'b0, ssa_s1} + {1'b0, cia};
				end
				pdc_pkg::MODE_SRC_OUT: begin
					x_c[l] = s_s1[l];
					if (full_s1) begin
						a_c[l] = {1'b0, nda};
					end else begin
						a_c[l] = {1'b0, nda_ca_s1};
						y_c[l] = d_s1[l];
						b_c[l] = {1'b0, cia};
					end
				end
				pdc_pkg::MODE_DST_OUT: begin
					x_c[l] = d_s1[l];
					a_c[l] = full_s1 ? {1'b0, nsa} : {1'b0, nsa_ca_s1} + {1'b0, cia};
				end
				pdc_pkg::MODE_SRC_ATOP: begin
					x_c[l] = ss_s1[l];
					a_c[l] = {1'b0, da};
					y_c[l] = d_s1[l];
					b_c[l] = {1'b0, nssa};
				end
				pdc_pkg::MODE_DST_ATOP: begin
					if (full_s1) begin
						x_c[l] = d_s1[l];
						a_c[l] = {1'b0, sa};
						y_c[l] = s_s1[l];
						b_c[l] = {1'b0, nda};
					end else begin
						x_c[l] = ss_s1[l];
						a_c[l] = {1'b0, nda};
						y_c[l] = d_s1[l];
						b_c[l] = {1'b0, ssa_s1} + {1'b0, cia};
					end
				end
				pdc_pkg::MODE_XOR: begin
					x_c[l] = ss_s1[l];
					a_c[l] = {1'b0, nda};
					y_c[l] = d_s1[l];
					b_c[l] = {1'b0, nssa};
				end
				default: begin
					// destination and unused codes pass the pixel through
					e_c[l] = d_s1[l];
				end
			endcase
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (en) begin
			span_s2 <= span_s1;
			x_s2    <= x_c;
			a_s2    <= a_c;
			y_s2    <= y_c;
			b_s2    <= b_c;
			e_s2    <= e_c;
		end
	end

	// stage 3 logic: lane products keep their low 16 bits
	always_comb begin
		logic [W:0] m1, m2;
		for (int l = 0; l < L; l++) begin
			m1 = {{(W-B+1){1'b0}}, x_s2[l]} * {{(W-B){1'b0}}, a_s2[l]};
			m2 = {{(W-B+1){1'b0}}, y_s2[l]} * {{(W-B){1'b0}}, b_s2[l]};
			p1_c[l] = m1[W-1:0];
			p2_c[l] = m2[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			span_s3 <= span_s2;
			p1_s3   <= p1_c;
			p2_s3   <= p2_c;
			e_s3    <= e_s2;
		end
	end

	// stage 4 logic: saturating sum and rounding
	always_comb begin
		for (int l = 0; l < L; l++) begin
			r_c[l] = pdc_pkg::lane_round(pdc_pkg::sat_add16(p1_s3[l], p2_s3[l]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			span_s4 <= span_s3;
			r_s4    <= r_c;
			e_s4    <= e_s3;
		end
	end

	// final add and clamp to a byte per channel
	always_comb begin
		logic [B:0] sum;
		for (int l = 0; l < L; l++) begin
			sum = {1'b0, r_s4[l]} + {1'b0, e_s4[l]};
			fin_c[l*B +: B] = sum[B] ? pdc_pkg::BYTE_FULL : sum[B-1:0];
		end
	end

	// output register loads when empty or being taken
	assign load_out = !out_vld_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (load_out) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q  <= vld_s4;
			end
		end else if (vld_s4 && en) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_pix_q  <= skid_vld_q ? skid_pix_q : fin_c;
			out_span_q <= skid_vld_q ? skid_span_q : span_s4;
		end else if (en) begin
			skid_pix_q  <= fin_c;
			skid_span_q <= span_s4;
		end
	end

	assign res_valid    = out_vld_q;
	assign result_pixel = out_pix_q;
	assign span_end_out = out_span_q;

endmodule

FILE: sim/tb_porter_duff_pixel_compositor_top.sv
// testbench for porter_duff_pixel_compositor_top: directed table, then random pixels per mode
// depends on pdc_pkg (mode codes) and the compositor top level
module tb_porter_duff_pixel_compositor_top;

	localparam logic [3:0]  MODE_UNUSED_LO = 4'd12;
	localparam logic [3:0]  MODE_UNUSED_HI = 4'd15;
	localparam logic [15:0] HALF_UNIT      = 16'h0080;
	localparam logic [15:0] BYTE_ONES      = 16'h00ff;
	localparam logic [15:0] LANE_ONES      = 16'hffff;
	localparam int          RESET_CYCLES   = 6;
	localparam int          SETTLE_CYCLES  = 8;
	localparam int          HOLD_CYCLES    = 300;
	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          PHASES         = 16;
	localparam int          PHASE_ITEMS    = 125;
	localparam int          NUM_CASES      = 25;

	typedef struct packed {
		logic [31:0] pixel;
		logic        span;
	} composited_t;

	typedef struct packed {
		logic [3:0]  mode;
		logic [31:0] src;
		logic [31:0] dst;
		logic [7:0]  cov;
		logic        span;
		logic        known;
		logic [31:0] want;
	} pixel_case_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [3:0]  cfg_data = 4'd0;
	logic        pix_valid = 1'b0;
	logic        pix_stall;
	logic [31:0] src_pixel = 32'd0;
	logic [31:0] dest_pixel = 32'd0;
	logic [7:0]  coverage = 8'd0;
	logic        span_end = 1'b0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [31:0] result_pixel;
	logic        span_end_out;

	composited_t pending_pixels[$];
	logic [3:0]  mode_now = pdc_pkg::MODE_SRC_OVER;
	int          errors = 0;
	int unsigned send_gap_pct = 0;
	int unsigned res_stall_pct = 0;
	int          hold_requests = 0;
	int          hold_taken = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;

	// directed pixels, fixed result only where it is obvious
	pixel_case_t directed_pixels [NUM_CASES] = '{
		'{pdc_pkg::MODE_SRC_OVER, 32'h00000000, 32'h00000000, 8'h00, 1'b0, 1'b1, 32'h00000000},
		'{pdc_pkg::MODE_SRC_OVER, 32'hffffffff, 32'hffffffff, 8'hff, 1'b1, 1'b0, 32'h0},
		'{pdc_pkg::MODE_SRC_OVER, 32'h80402010, 32'hff808080, 8'hff, 1'b0, 1'b0, 32'h0},
		'{pdc_pkg::MODE_SRC_OVER, 32'h80402010, 32'hff808080, 8'h80, 1'b1, 1'b0, 32'h0},
		'{pdc_pkg::MODE_DST_OVER, 32'h40201008, 32'h80ff0000, 8'hff, 1'b0, 1'b0, 32'h0},
		'{pdc_pkg::MODE_DST_OVER, 32'h40201008, 32'h80ff0000, 8'h33, 1'b0, 1'b0, 32'h0},
		'{pdc_pkg::MODE_CLEAR,    32'h12345678, 32'h87654321, 8'hff, 1'b1, 1'b1, 32'h00000000},
		'{pdc_pkg::MODE_CLEAR,    32'h12345678, 32'h87654321, 8'h40, 1'b0, 1'b0, 32'h0},
		'{pdc_pkg::MODE_SOURCE,   32'hff00ff00, 32'h80808080, 8'hff, 1'b0, 1'b1, 32'hff00ff00},
		'{pdc_pkg::MODE_SOURCE,   32'hff00ff00, 32'h80808080, 8'h7f, 1'b1, 1'b0, 32'h0},
		'{pdc_pkg::MODE_DEST,     32'hdeadbeef, 32'h01020304, 8'h55, 1'b0, 1'b1, 32'h01020304},
		'{pdc_pkg::MODE_SRC_IN,   32'hc0a08060, 32'h80402000, 8'hff, 1'b0, 1'b0, 32'h0},
		'{pdc_pkg::MODE_SRC_IN,   32'hc0a08060, 32'h80402000, 8'h00, 1'b0, 1'b0, 32'h0},
		'{pdc_pkg::MODE_DST_IN,   32'hf0e0d0c0, 32'hffffffff, 8'hff, 1'b1, 1'b0, 32'h0},
		'{pdc_pkg::MODE_DST_IN,   32'hf0e0d0c0, 32'hffffffff, 8'h90, 1'b0, 1'b0, 32'h0},
		'{pdc_pkg::MODE_SRC_OUT,  32'hffc08040, 32'h40302010, 8'hff, 1'b0, 1'b0, 32'h0},
		'{pdc_pkg::MODE_SRC_OUT,  32'hffc08040, 32'h40302010, 8'h10, 1'b1, 1'b0, 32'h0},
		'{pdc_pkg::MODE_DST_OUT,  32'h7f7f7f7f, 32'hfffefdfc, 8'hff, 1'b0, 1'b0, 32'h0},
		'{pdc_pkg::MODE_DST_OUT,  32'h7f7f7f7f, 32'hfffefdfc, 8'ha0, 1'b0, 1'b0, 32'h0},
		'{pdc_pkg::MODE_SRC_ATOP, 32'h9060300f, 32'hc0c0c0c0, 8'hff, 1'b1, 1'b0, 32'h0},
		'{pdc_pkg::MODE_DST_ATOP, 32'h9060300f, 32'h60504030, 8'hff, 1'b0, 1'b0, 32'h0},
		'{pdc_pkg::MODE_DST_ATOP, 32'hff306090, 32'h60504030, 8'hc8, 1'b0, 1'b0, 32'h0},
		'{pdc_pkg::MODE_XOR,      32'hffffffff, 32'hff000000, 8'hff, 1'b0, 1'b0, 32'h0},
		'{MODE_UNUSED_HI,         32'hcafebabe, 32'h13579bdf, 8'h80, 1'b1, 1'b1, 32'h13579bdf},
		'{MODE_UNUSED_LO,         32'h00ff00ff, 32'hfedcba98, 8'hff, 1'b0, 1'b1, 32'hfedcba98}
	};

	porter_duff_pixel_compositor_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.pix_valid    (pix_valid),
		.pix_stall    (pix_stall),
		.src_pixel    (src_pixel),
		.dest_pixel   (dest_pixel),
		.coverage     (coverage),
		.span_end     (span_end),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.result_pixel (result_pixel),
		.span_end_out (span_end_out)
	);

	always #5 clk = ~clk;

	// 16-bit lane arithmetic: saturating add, wrapping multiply
	function automatic logic [15:0] lane_sum(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = a + b;
		return s[16] ? LANE_ONES : s[15:0];
	endfunction

	function automatic logic [15:0] lane_prod(input logic [15:0] a, input logic [15:0] b);
		logic [31:0] p;
		p = a * b;
		return p[15:0];
	endfunction

	function automatic logic [15:0] lane_inv(input logic [15:0] a);
		return a ^ BYTE_ONES;
	endfunction

	// divide by 255 with rounding
	function automatic logic [15:0] lane_div255(input logic [15:0] t);
		logic [15:0] t1;
		logic [15:0] t2;
		t1 = lane_sum(t, HALF_UNIT);
		t2 = lane_sum(t1, t1 >> 8);
		return t2 >> 8;
	endfunction

	function automatic logic [15:0] lane_scale(input logic [15:0] a, input logic [15:0] b);
		return lane_div255(lane_prod(a, b));
	endfunction

	function automatic logic [15:0] lane_mix(input logic [15:0] x, input logic [15:0] a,
			input logic [15:0] y, input logic [15:0] b);
		return lane_div255(lane_sum(lane_prod(x, a), lane_prod(y, b)));
	endfunction

	// one channel under the given mode
	function automatic logic [15:0] composite_lane(input logic [3:0] mode,
			input logic [15:0] s, input logic [15:0] d, input logic [15:0] sa,
			input logic [15:0] da, input logic [15:0] ca);
		logic        full;
		logic [15:0] cia;
		logic [15:0] ss;
		logic [15:0] ssa;
		logic [15:0] dia;
		logic [15:0] r;
		full = (ca == BYTE_ONES);
		cia = lane_inv(ca);
		ss = full ? s : lane_scale(s, ca);
		ssa = full ? sa : lane_scale(sa, ca);
		case (mode)
			pdc_pkg::MODE_SRC_OVER: r = lane_sum(ss, lane_scale(d, lane_inv(ssa)));
			pdc_pkg::MODE_DST_OVER: begin
				dia = lane_inv(da);
				if (!full)
					dia = lane_scale(dia, ca);
				r = lane_sum(d, lane_scale(s, dia));
			end
			pdc_pkg::MODE_CLEAR: r = full ? 16'h0000 : lane_scale(d, cia);
			pdc_pkg::MODE_SOURCE: r = full ? s : lane_mix(s, ca, d, cia);
			pdc_pkg::MODE_SRC_IN: r = full ? lane_scale(s, da)
					: lane_mix(s, lane_scale(da, ca), d, cia);
			pdc_pkg::MODE_DST_IN: r = full ? lane_scale(d, sa)
					: lane_scale(d, lane_sum(lane_scale(sa, ca), cia));
			pdc_pkg::MODE_SRC_OUT: r = full ? lane_scale(s, lane_inv(da))
					: lane_mix(s, lane_scale(lane_inv(da), ca), d, cia);
			pdc_pkg::MODE_DST_OUT: r = full ? lane_scale(d, lane_inv(sa))
					: lane_scale(d, lane_sum(lane_scale(lane_inv(sa), ca), cia));
			pdc_pkg::MODE_SRC_ATOP: r = lane_mix(ss, da, d, lane_inv(ssa));
			pdc_pkg::MODE_DST_ATOP: r = full ? lane_mix(d, sa, s, lane_inv(da))
					: lane_mix(ss, lane_inv(da), d, lane_sum(ssa, cia));
			pdc_pkg::MODE_XOR: r = lane_mix(ss, lane_inv(da), d, lane_inv(ssa));
			default: r = d;
		endcase
		return r;
	endfunction

	// full pixel: four lanes, each clamped to a byte, negative lanes to zero
	function automatic logic [31:0] composite_pixel(input logic [3:0] mode,
			input logic [31:0] src, input logic [31:0] dst, input logic [7:0] cov);
		logic [31:0] res;
		logic [15:0] v;
		res = 32'd0;
		for (int sh = 0; sh < 32; sh += 8) begin
			v = composite_lane(mode, {8'd0, src[sh +: 8]}, {8'd0, dst[sh +: 8]},
					{8'd0, src[31:24]}, {8'd0, dst[31:24]}, {8'd0, cov});
			if (v[15])
				res[sh +: 8] = 8'd0;
			else if (v > BYTE_ONES)
				res[sh +: 8] = 8'hff;
			else
				res[sh +: 8] = v[7:0];
		end
		return res;
	endfunction

	// mostly premultiplied pixels, some raw and extreme ones
	function automatic logic [31:0] random_pixel();
		logic [31:0] p;
		logic [7:0]  a;
		int unsigned kind;
		kind = $urandom_range(99);
		if (kind < 20) begin
			p = $urandom;
		end else if (kind < 26) begin
			p = 32'h00000000;
		end else if (kind < 32) begin
			p = 32'hffffffff;
		end else begin
			a = (kind < 45) ? 8'hff : 8'($urandom_range(255));
			p[31:24] = a;
			for (int sh = 0; sh < 24; sh += 8)
				p[sh +: 8] = 8'($urandom_range(a));
		end
		return p;
	endfunction

	function automatic logic [7:0] random_coverage();
		int unsigned kind;
		kind = $urandom_range(99);
		if (kind < 30)
			return 8'hff;
		if (kind < 38)
			return 8'h00;
		return 8'($urandom_range(255));
	endfunction

	// offer one item, entered and left at a falling edge
	task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst,
			input logic [7:0] cov, input logic span, input logic known,
			input logic [31:0] want);
		composited_t item;
		while ($urandom_range(99) < send_gap_pct) begin
			pix_valid <= 1'b0;
			@(negedge clk);
		end
		pix_valid <= 1'b1;
		src_pixel <= src;
		dest_pixel <= dst;
		coverage <= cov;
		span_end <= span;
		@(posedge clk);
		while (pix_stall)
			@(posedge clk);
		item.pixel = known ? want : composite_pixel(mode_now, src, dst, cov);
		item.span = span;
		pending_pixels.push_back(item);
		@(negedge clk);
	endtask

	// wait for the block to empty, then write the mode register
	task automatic write_mode(input logic [3:0] mode);
		pix_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= mode;
		@(negedge clk);
		cfg_we <= 1'b0;
		mode_now = mode;
	endtask

	// result side stall, with long hold-offs on request
	always @(negedge clk) begin
		if (hold_requests != hold_taken) begin
			hold_taken = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			res_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			res_stall <= ($urandom_range(99) < res_stall_pct);
		end
	end

	// compare each result with the oldest expected pixel
	always @(posedge clk) begin : check_results
		composited_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_pixels.size() == 0) begin
				errors++;
				$display("%0t: result %h with nothing expected", $time, result_pixel);
			end else begin
				want = pending_pixels.pop_front();
				if (result_pixel !== want.pixel) begin
					errors++;
					$display("%0t: result_pixel expected %h actual %h",
							$time, want.pixel, result_pixel);
				end
				if (span_end_out !== want.span) begin
					errors++;
					$display("%0t: span_end_out expected %b actual %b",
							$time, want.span, span_end_out);
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (!arst_n || (pix_valid && !pix_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// stimulus
	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part, mode changes only between drained items
		for (int i = 0; i < NUM_CASES; i++) begin
			if (directed_pixels[i].mode != mode_now)
				write_mode(directed_pixels[i].mode);
			send_pixel(directed_pixels[i].src, directed_pixels[i].dst,
					directed_pixels[i].cov, directed_pixels[i].span,
					directed_pixels[i].known, directed_pixels[i].want);
		end

		// random part, every mode code once, idling pattern rotating
		for (int p = 0; p < PHASES; p++) begin
			write_mode(4'((p * 7) % 16));
			case (p % 4)
				0: begin send_gap_pct = 0; res_stall_pct = 0; end
				1: begin send_gap_pct = 61; res_stall_pct = 0; end
				2: begin send_gap_pct = 0; res_stall_pct = 61; end
				default: begin send_gap_pct = 37; res_stall_pct = 37; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long result hold-off while items keep coming
				if (n == 50 && (p == 0 || p == 5))
					hold_requests++;
				send_pixel(random_pixel(), random_pixel(), random_coverage(),
						($urandom_range(7) == 0), 1'b0, 32'h0);
			end
		end

		// drain
		pix_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
